### src/oegt_pkg.sv
// Package for the oscillation envelope gain tuner.
// Field widths, verdict codes, register indexes and shared word types.
// No dependencies.
`timescale 1ns / 1ps

package oegt_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int GAIN_W        = 20;
   localparam int THRESH_W      = 17;
   localparam int VERDICT_W     = 3;
   localparam int CSR_INDEX_W   = 1;

   localparam int DWELL_LIMIT_DEFAULT       = 10;
   localparam int EXTREMA_PER_ROUND_DEFAULT = 5;

   localparam logic [THRESH_W-1:0] UPPER_THRESHOLD_RESET = 17'sd500;
   localparam logic [THRESH_W-1:0] LOWER_THRESHOLD_RESET = -17'sd500;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_UPPER_THRESHOLD = 1'b0,
      CSR_LOWER_THRESHOLD = 1'b1
   } csr_index_type;

   // Verdict codes
   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_MOVING    = 3'd0,
      VERDICT_DIVERGING = 3'd1,
      VERDICT_DECAYING  = 3'd2,
      VERDICT_SETTLED   = 3'd3,
      VERDICT_NONE      = 3'd4
   } verdict_type;

   // Drift thresholds as held by the register block
   typedef struct packed {
      logic signed [THRESH_W-1:0] upper;
      logic signed [THRESH_W-1:0] lower;
   } thresholds_type;

   // One result word
   typedef struct packed {
      verdict_type        verdict;
      logic [GAIN_W-1:0]  gain;
   } result_type;

endpackage

### src/oegt_csr.sv
// Threshold register block of the oscillation envelope gain tuner.
// Depends on oegt_pkg.
`timescale 1ns / 1ps

module oegt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [oegt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [oegt_pkg::THRESH_W-1:0]       csr_write_data,
   output oegt_pkg::thresholds_type            thresholds
);

   oegt_pkg::thresholds_type thresholds_ff, thresholds_in;

   // Register write decode
   always_comb begin
      thresholds_in = thresholds_ff;
      if (csr_write_enable) begin
         case (oegt_pkg::csr_index_type'(csr_index))
            oegt_pkg::CSR_UPPER_THRESHOLD: thresholds_in.upper = csr_write_data;
            oegt_pkg::CSR_LOWER_THRESHOLD: thresholds_in.lower = csr_write_data;
            default: thresholds_in = thresholds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresholds_ff.upper <= oegt_pkg::UPPER_THRESHOLD_RESET;
         thresholds_ff.lower <= oegt_pkg::LOWER_THRESHOLD_RESET;
      end else begin
         thresholds_ff <= thresholds_in;
      end
   end

   assign thresholds = thresholds_ff;

endmodule

### src/oegt_core.sv
// Extreme tracker and drift decision of the oscillation envelope gain tuner.
// Holds the phase, dwell and extremum stores; one sample per step_en.
// Depends on oegt_pkg.
`timescale 1ns / 1ps

module oegt_core #(
   parameter int DWELL_LIMIT       = oegt_pkg::DWELL_LIMIT_DEFAULT,
   parameter int EXTREMA_PER_ROUND = oegt_pkg::EXTREMA_PER_ROUND_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step_en,
   input  logic [oegt_pkg::SAMPLE_W-1:0]   sample,
   input  logic [oegt_pkg::GAIN_W-1:0]     gain_in,
   input  oegt_pkg::thresholds_type        thresholds,
   output oegt_pkg::result_type            result
);

   localparam int DW = $clog2(DWELL_LIMIT + 1);
   localparam int CW = $clog2(EXTREMA_PER_ROUND + 1);
   localparam int IW = $clog2(EXTREMA_PER_ROUND);
   localparam int SW = oegt_pkg::SAMPLE_W;
   localparam int TW = oegt_pkg::THRESH_W;
   localparam logic [DW-1:0] DWELL_MAX = DW'(DWELL_LIMIT);
   localparam logic [CW-1:0] ROUND_FULL = CW'(EXTREMA_PER_ROUND);
   localparam logic [IW-1:0] LAST_IDX = IW'(EXTREMA_PER_ROUND - 1);

   logic          rising_ff, rising_in;
   logic [SW-1:0] last_extreme_ff, last_extreme_in;
   logic [DW-1:0] dwell_ff, dwell_in;
   logic [CW-1:0] peak_cnt_ff, peak_cnt_in;
   logic [CW-1:0] valley_cnt_ff, valley_cnt_in;
   logic [SW-1:0] peak_store_ff [EXTREMA_PER_ROUND];
   logic [SW-1:0] valley_store_ff [EXTREMA_PER_ROUND];

   logic          cont;
   logic          turn;
   logic          peak_wr, valley_wr;
   logic          round_done;
   logic [SW-1:0] peak_last, valley_last;
   logic signed [TW-1:0] pd, vd;
   logic          gain_zero, gain_max;

   // Direction and turn detection
   assign cont    = rising_ff ? (sample > last_extreme_ff) : (sample < last_extreme_ff);
   assign turn    = !cont && (dwell_ff >= DWELL_MAX);
   assign peak_wr   = turn && rising_ff && (peak_cnt_ff < ROUND_FULL);
   assign valley_wr = turn && !rising_ff && (valley_cnt_ff < ROUND_FULL);

   // Last entries, with bypass of the value being stored this step
   assign peak_last   = (peak_wr && peak_cnt_ff[IW-1:0] == LAST_IDX) ? last_extreme_ff
                                                                      : peak_store_ff[LAST_IDX];
   assign valley_last = (valley_wr && valley_cnt_ff[IW-1:0] == LAST_IDX) ? last_extreme_ff
                                                                         : valley_store_ff[LAST_IDX];

   // Drift, last minus first
   assign pd = $signed({1'b0, peak_last}) - $signed({1'b0, peak_store_ff[0]});
   assign vd = $signed({1'b0, valley_last}) - $signed({1'b0, valley_store_ff[0]});

   assign gain_zero = (gain_in == '0);
   assign gain_max  = (gain_in == '1);

   // Next state and verdict
   always_comb begin
      rising_in       = rising_ff;
      last_extreme_in = last_extreme_ff;
      dwell_in        = dwell_ff;
      peak_cnt_in     = peak_cnt_ff + CW'(peak_wr);
      valley_cnt_in   = valley_cnt_ff + CW'(valley_wr);
      round_done      = 1'b0;
      result.verdict  = oegt_pkg::VERDICT_NONE;
      result.gain     = gain_in;

      if (cont) begin
         last_extreme_in = sample;
         dwell_in        = '0;
         result.verdict  = oegt_pkg::VERDICT_MOVING;
      end else begin
         if (turn) begin
            last_extreme_in = sample;
            dwell_in        = '0;
            rising_in       = !rising_ff;
         end else begin
            dwell_in = dwell_ff + DW'(1);
         end

         round_done = (peak_cnt_in == ROUND_FULL) && (valley_cnt_in == ROUND_FULL);
         if (round_done) begin
            peak_cnt_in   = '0;
            valley_cnt_in = '0;
            if (pd > thresholds.upper && vd < thresholds.lower) begin
               result.verdict = oegt_pkg::VERDICT_DIVERGING;
               if (!gain_zero) result.gain = gain_in - 1'b1;
            end else if (pd < thresholds.lower && vd > thresholds.upper) begin
               result.verdict = oegt_pkg::VERDICT_DECAYING;
               if (!gain_max) result.gain = gain_in + 1'b1;
            end else if (pd < thresholds.upper && pd > thresholds.lower &&
                         vd < thresholds.upper && vd > thresholds.lower) begin
               result.verdict = oegt_pkg::VERDICT_SETTLED;
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rising_ff       <= 1'b1;
         last_extreme_ff <= '0;
         dwell_ff        <= '0;
         peak_cnt_ff     <= '0;
         valley_cnt_ff   <= '0;
      end else if (step_en) begin
         rising_ff       <= rising_in;
         last_extreme_ff <= last_extreme_in;
         dwell_ff        <= dwell_in;
         peak_cnt_ff     <= peak_cnt_in;
         valley_cnt_ff   <= valley_cnt_in;
      end
   end

   // Extremum stores; an entry is always written before the round reads it
   always_ff @(posedge clock) begin
      if (step_en && peak_wr) begin
         peak_store_ff[peak_cnt_ff[IW-1:0]] <= last_extreme_ff;
      end
      if (step_en && valley_wr) begin
         valley_store_ff[valley_cnt_ff[IW-1:0]] <= last_extreme_ff;
      end
   end

endmodule

### src/oscillation_envelope_gain_tuner.sv
// Top level of the oscillation envelope gain tuner.
// Input register, result register and handshake; uses oegt_csr, oegt_core, oegt_pkg.
`timescale 1ns / 1ps

// Usage:
//   req_* carries one word per sample: the response sample and the current
//   gain. rsp_* returns one word per sample: a verdict and the adjusted gain.
//   Both channels use valid/ready; a word moves when valid and ready are high.
//   csr_* writes the two drift thresholds (index 0 upper, 1 lower); write
//   only while no word is in flight.
// Path: an accepted word waits in the input register, is loaded into the
//   result register when it advances and shows on rsp_* from then on until
//   it leaves.
// Throughput: one word per cycle while rsp_ready is high. The tracker state
//   is updated as a word moves from the input register into the result
//   register, so the next word sees it in the following cycle.
// Stall: while rsp_ready is low the result register holds; the input
//   register still takes one more word, after which req_ready drops.
// Reset (synchronous, active high): both registers empty, phase seeking a
//   peak, counts cleared, thresholds back to +500 and -500.

module oscillation_envelope_gain_tuner #(
   parameter int DWELL_LIMIT       = oegt_pkg::DWELL_LIMIT_DEFAULT,
   parameter int EXTREMA_PER_ROUND = oegt_pkg::EXTREMA_PER_ROUND_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [oegt_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic [oegt_pkg::GAIN_W-1:0]        req_gain_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [oegt_pkg::VERDICT_W-1:0]     rsp_verdict,
   output logic [oegt_pkg::GAIN_W-1:0]        rsp_gain_out,
   input  logic                               csr_write_enable,
   input  logic [oegt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [oegt_pkg::THRESH_W-1:0]      csr_write_data
);

   logic                          in_valid_ff, in_valid_in;
   logic [oegt_pkg::SAMPLE_W-1:0] in_sample_ff;
   logic [oegt_pkg::GAIN_W-1:0]   in_gain_ff;
   logic                          out_valid_ff, out_valid_in;
   oegt_pkg::result_type          out_word_ff;
   oegt_pkg::result_type          step_result;
   oegt_pkg::thresholds_type      thresholds;
   logic                          advance;
   logic                          req_take;

   oegt_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .thresholds       (thresholds)
   );

   oegt_core #(
      .DWELL_LIMIT       (DWELL_LIMIT),
      .EXTREMA_PER_ROUND (EXTREMA_PER_ROUND)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .sample     (in_sample_ff),
      .gain_in    (in_gain_ff),
      .thresholds (thresholds),
      .result     (step_result)
   );

   // Handshake: a word advances when the result register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_sample;
         in_gain_ff   <= req_gain_in;
      end
      if (advance) begin
         out_word_ff <= step_result;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_verdict  = out_word_ff.verdict;
   assign rsp_gain_out = out_word_ff.gain;

endmodule
